### src/fbsf_pkg.sv
// ----------------------------------------------------------------------------
// fbsf_pkg
// Types and fixed constants shared by the framebuffer shape fill engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsf_pkg;

  // Widths fixed by the command and result formats.
  localparam int COORD_W = 12;
  localparam int RAD_W   = 11;
  localparam int PIXEL_W = 4;

  // Working width for clipped bounds and offsets from the circle centre.
  localparam int CW  = 14;
  // Width of squared distances; their sum takes one bit more.
  localparam int SQW = 2 * CW - 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_RECT   = 2'd1,
    OP_CIRCLE = 2'd2,
    OP_READ   = 2'd3
  } fbsf_op_t;

  typedef struct packed {
    fbsf_op_t                   operation;
    logic signed [COORD_W-1:0]  x_a;
    logic signed [COORD_W-1:0]  y_a;
    logic signed [COORD_W-1:0]  x_b;
    logic signed [COORD_W-1:0]  y_b;
    logic        [RAD_W-1:0]    radius;
    logic        [PIXEL_W-1:0]  color;
  } fbsf_cmd_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_color;
    logic               out_of_range;
  } fbsf_res_t;

endpackage

`default_nettype wire

### src/fbsf_if.sv
// ----------------------------------------------------------------------------
// fbsf_if
// Valid/ready channels for commands and read results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbsf_cmd_if;
  logic                valid;
  logic                ready;
  fbsf_pkg::fbsf_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fbsf_res_if;
  logic                valid;
  logic                ready;
  fbsf_pkg::fbsf_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/framebuffer_shape_fill.sv
// ----------------------------------------------------------------------------
// framebuffer_shape_fill
// Clear, rectangle and circle fill engine over a framebuffer, with pixel read.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake        Payload
//   in_ch    in   valid / ready    operation, x_a, y_a, x_b, y_b, radius, color
//   out_ch   out  valid / ready    pixel_color, out_of_range (read items only)
//
// in_ch.ready is high only in idle. A clear walks all W*H pixels, a rectangle
// its clipped area, a circle its clipped bounding box. One shared multiplier
// forms the first row base, read addresses, the squared radius and the squared
// offsets at each circle row start. A read result waits in the output
// register; a later read stalls in its last cycle until it leaves. Reset
// clears the sequencer and the output valid; the frame is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_shape_fill #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 600,
  parameter int COLOR_BITS    = 4
) (
  input wire logic  clk,
  input wire logic  rst_n,
  fbsf_cmd_if.sink  in_ch,
  fbsf_res_if.source out_ch
);

  import fbsf_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int SB    = (COLOR_BITS >= PIXEL_W) ? PIXEL_W : COLOR_BITS;

  localparam logic signed [CW-1:0] W_C    = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] XMAX_C = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] YMAX_C = CW'(SCREEN_HEIGHT - 1);
  localparam logic signed [CW-1:0] H_C    = CW'(SCREEN_HEIGHT);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_SETUP   = 11'b000_0000_0010,
    ST_BASE    = 11'b000_0000_0100,
    ST_BASE_LD = 11'b000_0000_1000,
    ST_R_LD    = 11'b000_0001_0000,
    ST_ROW_DY  = 11'b000_0010_0000,
    ST_ROW_DX  = 11'b000_0100_0000,
    ST_ROW_LD  = 11'b000_1000_0000,
    ST_SPAN    = 11'b001_0000_0000,
    ST_RD_ADDR = 11'b010_0000_0000,
    ST_RD_DATA = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Command held for the duration of the item.
  fbsf_op_t                 op_r, op_nxt;
  logic signed [CW-1:0]     xa_r, xa_nxt, ya_r, ya_nxt;
  logic signed [CW-1:0]     xb_r, xb_nxt, yb_r, yb_nxt;
  logic signed [CW-1:0]     rad_r, rad_nxt;
  logic [SB-1:0]            color_r, color_nxt;

  // Walk state.
  logic [XW-1:0]            xl_r, xl_nxt, xh_r, xh_nxt, x_r, x_nxt;
  logic [YW-1:0]            yh_r, yh_nxt, y_r, y_nxt;
  logic [AW-1:0]            base_r, base_nxt;
  logic signed [CW-1:0]     dx_r, dx_nxt;
  logic [SQW-1:0]           dx2_r, dx2_nxt, dy2_r, dy2_nxt, r2_r, r2_nxt;
  logic                     oor_r, oor_nxt;

  // Shared multiplier with a registered product.
  logic signed [CW-1:0]     mul_a, mul_b;
  logic signed [2*CW-1:0]   prod_r;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]       pix_r, pix_nxt;
  logic                     res_oor_r, res_oor_nxt;

  // RAM ports.
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [SB-1:0]            ram_rdata;

  // Bounding box of the command, before and after clipping.
  logic signed [CW-1:0]     lo_x, hi_x, lo_y, hi_y;
  logic signed [CW-1:0]     cl_xl, cl_xh, cl_yl, cl_yh;
  logic                     box_empty, rd_inside;

  logic signed [CW-1:0]     x_s, y_s, dy_cur, dx_cur;
  logic signed [CW:0]       dx_step;
  logic [SQW:0]             dist2;
  logic                     in_disc, row_end, last_row;

  fbsf_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (color_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (op_r)
      OP_RECT: begin
        lo_x = xa_r; hi_x = xb_r; lo_y = ya_r; hi_y = yb_r;
      end
      OP_CIRCLE: begin
        lo_x = xa_r - rad_r; hi_x = xa_r + rad_r;
        lo_y = ya_r - rad_r; hi_y = ya_r + rad_r;
      end
      default: begin
        lo_x = '0; hi_x = XMAX_C; lo_y = '0; hi_y = YMAX_C;
      end
    endcase
    cl_xl = (lo_x < 0) ? CW'(0) : lo_x;
    cl_xh = (hi_x > XMAX_C) ? XMAX_C : hi_x;
    cl_yl = (lo_y < 0) ? CW'(0) : lo_y;
    cl_yh = (hi_y > YMAX_C) ? YMAX_C : hi_y;
    box_empty = (cl_xl > cl_xh) || (cl_yl > cl_yh);
    rd_inside = (xa_r >= 0) && (xa_r < W_C) && (ya_r >= 0) && (ya_r < H_C);
  end

  assign x_s     = $signed(CW'(x_r));
  assign y_s     = $signed(CW'(y_r));
  assign dy_cur  = y_s - ya_r;
  assign dx_cur  = x_s - xa_r;
  assign dx_step = {dx_r, 1'b1};
  assign dist2   = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign in_disc = dist2 <= {1'b0, r2_r};
  assign row_end  = (x_r == xh_r);
  assign last_row = (y_r == yh_r);

  always_comb begin
    case (state_r)
      ST_SETUP:  begin mul_a = ya_r;              mul_b = W_C;    end
      ST_BASE:   begin mul_a = $signed(CW'(y_r)); mul_b = W_C;    end
      ST_BASE_LD: begin mul_a = rad_r;            mul_b = rad_r;  end
      ST_ROW_DY: begin mul_a = dy_cur;            mul_b = dy_cur; end
      ST_ROW_DX: begin mul_a = dx_cur;            mul_b = dx_cur; end
      default:   begin mul_a = '0;                mul_b = '0;     end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign ram_waddr = base_r + AW'(x_r);
  assign ram_we    = (state_r == ST_SPAN) && ((op_r != OP_CIRCLE) || in_disc);
  assign ram_re    = (state_r == ST_RD_ADDR);
  // The row base of a read is formed during setup, so the product is ready
  // when the read is issued.
  assign ram_raddr = prod_r[AW-1:0] + AW'(xa_r);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    xa_nxt        = xa_r;
    ya_nxt        = ya_r;
    xb_nxt        = xb_r;
    yb_nxt        = yb_r;
    rad_nxt       = rad_r;
    color_nxt     = color_r;
    xl_nxt        = xl_r;
    xh_nxt        = xh_r;
    yh_nxt        = yh_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    base_nxt      = base_r;
    dx_nxt        = dx_r;
    dx2_nxt       = dx2_r;
    dy2_nxt       = dy2_r;
    r2_nxt        = r2_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pix_nxt       = pix_r;
    res_oor_nxt   = res_oor_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.data.operation;
          xa_nxt    = CW'(in_ch.data.x_a);
          ya_nxt    = CW'(in_ch.data.y_a);
          xb_nxt    = CW'(in_ch.data.x_b);
          yb_nxt    = CW'(in_ch.data.y_b);
          rad_nxt   = $signed(CW'(in_ch.data.radius));
          color_nxt = in_ch.data.color[SB-1:0];
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        xl_nxt = XW'(cl_xl);
        xh_nxt = XW'(cl_xh);
        yh_nxt = YW'(cl_yh);
        x_nxt  = XW'(cl_xl);
        y_nxt  = YW'(cl_yl);
        if (op_r == OP_READ) begin
          oor_nxt   = !rd_inside;
          state_nxt = rd_inside ? ST_RD_ADDR : ST_RD_DATA;
        end else if (box_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        state_nxt = ST_BASE_LD;
      end
      ST_BASE_LD: begin
        base_nxt  = prod_r[AW-1:0];
        state_nxt = (op_r == OP_CIRCLE) ? ST_R_LD : ST_SPAN;
      end
      ST_R_LD: begin
        r2_nxt    = prod_r[SQW-1:0];
        state_nxt = ST_ROW_DY;
      end
      ST_ROW_DY: begin
        state_nxt = ST_ROW_DX;
      end
      ST_ROW_DX: begin
        dy2_nxt   = prod_r[SQW-1:0];
        state_nxt = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        dx2_nxt   = prod_r[SQW-1:0];
        dx_nxt    = dx_cur;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        if (row_end) begin
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            x_nxt     = xl_r;
            y_nxt     = y_r + YW'(1);
            base_nxt  = base_r + AW'(SCREEN_WIDTH);
            state_nxt = (op_r == OP_CIRCLE) ? ST_ROW_DY : ST_SPAN;
          end
        end else begin
          x_nxt   = x_r + XW'(1);
          dx_nxt  = dx_r + CW'(1);
          // (dx+1)^2 = dx^2 + 2dx + 1; the step may be negative.
          dx2_nxt = dx2_r + SQW'(dx_step);
        end
      end
      ST_RD_ADDR: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          pix_nxt       = oor_r ? '0 : PIXEL_W'(ram_rdata);
          res_oor_nxt   = oor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    xa_r      <= xa_nxt;
    ya_r      <= ya_nxt;
    xb_r      <= xb_nxt;
    yb_r      <= yb_nxt;
    rad_r     <= rad_nxt;
    color_r   <= color_nxt;
    xl_r      <= xl_nxt;
    xh_r      <= xh_nxt;
    yh_r      <= yh_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    base_r    <= base_nxt;
    dx_r      <= dx_nxt;
    dx2_r     <= dx2_nxt;
    dy2_r     <= dy2_nxt;
    r2_r      <= r2_nxt;
    oor_r     <= oor_nxt;
    pix_r     <= pix_nxt;
    res_oor_r <= res_oor_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.data.pixel_color  = pix_r;
  assign out_ch.data.out_of_range = res_oor_r;

  a_write_only_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_SPAN))
    else $error("frame write outside the pixel walk");

  a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPAN) |-> ((x_r >= xl_r) && (x_r <= xh_r) && (y_r <= yh_r)))
    else $error("pixel walk left its clipped box");

  a_oor_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_oor_r) |-> (pix_r == '0))
    else $error("off-screen read returned a nonzero colour");

  a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_SETUP))
    else $error("accepted item did not enter setup");

endmodule

`default_nettype wire

### src/fbsf_ram.sv
// ----------------------------------------------------------------------------
// fbsf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 480000,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
